// File: rtl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, checking held off while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// condition that must never be seen at a clock edge
`define ASSERT_NEVER(label, expr, msg) \
    `ASSERT_CLK(label, !(expr), msg)

`endif

// File: rtl/ppl_pkg.sv
package ppl_pkg;

    localparam int unsigned MAX_PATH_LEN_DEF = 65535;
    localparam int unsigned Q_DEPTH          = 4;

    localparam logic [30:0] IDX_MAX = 31'h7FFF_FFFF;

    localparam logic [15:0] CH_LBRACK = 16'h005B;
    localparam logic [15:0] CH_RBRACK = 16'h005D;
    localparam logic [15:0] CH_DOT    = 16'h002E;
    localparam logic [15:0] CH_USCORE = 16'h005F;

    typedef enum logic [1:0] {
        KIND_NAME = 2'd0,
        KIND_STEP = 2'd1,
        KIND_OK   = 2'd2,
        KIND_ERR  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ERR_IDENT     = 3'd0,
        ERR_DIGITS    = 3'd1,
        ERR_RBRACK    = 3'd2,
        ERR_RANGE     = 3'd3,
        ERR_DOT_END   = 3'd4,
        ERR_TRAIL_DOT = 3'd5
    } t_err;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_IDENT  = 3'd1,
        PH_OPEN   = 3'd2,
        PH_DIGITS = 3'd3,
        PH_CLOSED = 3'd4,
        PH_DOT    = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        TERM_NONE = 2'd0,
        TERM_OK   = 2'd1,
        TERM_ERR  = 2'd2
    } t_term;

    // all results of one character, always in the order name, step, terminal
    typedef struct packed {
        logic        has_name;
        logic [15:0] name_char;
        logic        has_step;
        logic        step_has_index;
        logic [30:0] step_index;
        t_term       term;
        t_err        err_code;
        logic [15:0] err_offset;
    } t_bundle;

    function automatic logic is_space(input logic [15:0] c);
        return (c == 16'h0020) || (c >= 16'h0009 && c <= 16'h000D) ||
               (c == 16'h0085) || (c == 16'h00A0) || (c == 16'h1680) ||
               (c >= 16'h2000 && c <= 16'h200A) ||
               (c == 16'h2028) || (c == 16'h2029) || (c == 16'h202F) ||
               (c == 16'h205F) || (c == 16'h3000);
    endfunction

    function automatic logic is_digit(input logic [15:0] c);
        return c >= 16'h0030 && c <= 16'h0039;
    endfunction

    function automatic logic is_start(input logic [15:0] c);
        return (c >= 16'h0041 && c <= 16'h005A) || (c >= 16'h0061 && c <= 16'h007A) ||
               (c == CH_USCORE);
    endfunction

endpackage

// File: rtl/ppl_front.sv
`include "assert_macros.svh"

module ppl_front #(
    parameter int unsigned MAX_PATH_LEN = ppl_pkg::MAX_PATH_LEN_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [15:0]      i_chr,
    input  logic             i_end_of_path,
    output logic             o_push,
    output ppl_pkg::t_bundle o_bundle
);
    import ppl_pkg::*;

    localparam int unsigned OFS_W = $clog2(MAX_PATH_LEN + 1);
    localparam logic [OFS_W-1:0] OFS_MAX = OFS_W'(MAX_PATH_LEN);

    t_phase           r_phase, n_phase;
    logic             r_started, n_started;
    logic             r_failed, n_failed;
    logic [OFS_W-1:0] r_char_off, n_char_off;
    logic             r_space_pend, n_space_pend;
    logic [OFS_W-1:0] r_space_off, n_space_off;
    logic [OFS_W-1:0] r_digit_start, n_digit_start;
    logic [30:0]      r_idx_acc, n_idx_acc;
    logic             r_idx_ovf, n_idx_ovf;

    function automatic logic [OFS_W-1:0] sat_inc(input logic [OFS_W-1:0] v);
        return (v < OFS_MAX) ? v + OFS_W'(1) : OFS_MAX;
    endfunction

    function automatic logic [15:0] ofs16(input logic [OFS_W-1:0] v);
        logic [OFS_W+15:0] w;
        w = {16'd0, v};
        return w[15:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_START;
            r_started     <= 1'b0;
            r_failed      <= 1'b0;
            r_char_off    <= '0;
            r_space_pend  <= 1'b0;
            r_space_off   <= '0;
            r_digit_start <= '0;
            r_idx_acc     <= '0;
            r_idx_ovf     <= 1'b0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_started     <= n_started;
            r_failed      <= n_failed;
            r_char_off    <= n_char_off;
            r_space_pend  <= n_space_pend;
            r_space_off   <= n_space_off;
            r_digit_start <= n_digit_start;
            r_idx_acc     <= n_idx_acc;
            r_idx_ovf     <= n_idx_ovf;
        end
    end

    always_comb begin
        t_bundle          b;
        logic             bad;
        logic [OFS_W-1:0] bad_off;
        logic [OFS_W-1:0] len;
        logic [34:0]      acc10;

        b             = '0;
        bad           = 1'b0;
        bad_off       = r_char_off;
        len           = '0;
        n_phase       = r_phase;
        n_started     = r_started;
        n_failed      = r_failed;
        n_char_off    = r_char_off;
        n_space_pend  = r_space_pend;
        n_space_off   = r_space_off;
        n_digit_start = r_digit_start;
        n_idx_acc     = r_idx_acc;
        n_idx_ovf     = r_idx_ovf;

        // multiply-by-ten accumulate with saturation
        acc10 = ({4'd0, r_idx_acc} << 3) + ({4'd0, r_idx_acc} << 1)
              + {19'd0, i_chr - 16'h0030};

        if (!r_failed) begin
            if (is_space(i_chr)) begin
                if (r_started) begin
                    if (!r_space_pend) begin
                        n_space_pend = 1'b1;
                        n_space_off  = r_char_off;
                    end
                    n_char_off = sat_inc(r_char_off);
                end
            end else begin
                n_started = 1'b1;
                if (r_space_pend) begin
                    bad     = 1'b1;
                    bad_off = r_space_off;
                end else begin
                    unique case (r_phase)
                        PH_IDENT: begin
                            if (is_start(i_chr) || is_digit(i_chr)) begin
                                b.has_name  = 1'b1;
                                b.name_char = i_chr;
                            end else if (i_chr == CH_LBRACK) begin
                                n_phase       = PH_OPEN;
                                n_digit_start = sat_inc(r_char_off);
                                n_idx_acc     = '0;
                                n_idx_ovf     = 1'b0;
                            end else if (i_chr == CH_DOT) begin
                                b.has_step = 1'b1;
                                n_phase    = PH_DOT;
                            end else begin
                                bad = 1'b1;
                            end
                        end
                        PH_OPEN, PH_DIGITS: begin
                            if (is_digit(i_chr)) begin
                                n_phase = PH_DIGITS;
                                if (acc10 > {4'd0, IDX_MAX}) begin
                                    n_idx_acc = IDX_MAX;
                                    n_idx_ovf = 1'b1;
                                end else begin
                                    n_idx_acc = acc10[30:0];
                                end
                            end else if (r_phase == PH_DIGITS && i_chr == CH_RBRACK) begin
                                if (r_idx_ovf) begin
                                    b.term       = TERM_ERR;
                                    b.err_code   = ERR_RANGE;
                                    b.err_offset = ofs16(r_digit_start);
                                    n_failed     = 1'b1;
                                end else begin
                                    b.has_step       = 1'b1;
                                    b.step_has_index = 1'b1;
                                    b.step_index     = r_idx_acc;
                                    n_phase          = PH_CLOSED;
                                end
                            end else begin
                                bad = 1'b1;
                            end
                        end
                        PH_CLOSED: begin
                            if (i_chr == CH_DOT) begin
                                n_phase = PH_DOT;
                            end else begin
                                bad = 1'b1;
                            end
                        end
                        default: begin
                            if (is_start(i_chr)) begin
                                b.has_name  = 1'b1;
                                b.name_char = i_chr;
                                n_phase     = PH_IDENT;
                            end else begin
                                bad = 1'b1;
                            end
                        end
                    endcase
                end
                n_char_off = sat_inc(r_char_off);
            end

            // character not allowed where it stands
            if (bad) begin
                b.term       = TERM_ERR;
                b.err_offset = ofs16(bad_off);
                n_failed     = 1'b1;
                unique case (r_phase)
                    PH_IDENT: begin
                        b.has_step = 1'b1;
                        b.err_code = ERR_DOT_END;
                    end
                    PH_OPEN: begin
                        b.err_code   = ERR_DIGITS;
                        b.err_offset = ofs16(r_digit_start);
                    end
                    PH_DIGITS: b.err_code = ERR_RBRACK;
                    PH_CLOSED: b.err_code = ERR_DOT_END;
                    default:   b.err_code = ERR_IDENT;
                endcase
            end

            // end of path on a clean run
            if (i_end_of_path && !n_failed) begin
                len = n_space_pend ? n_space_off : n_char_off;
                unique case (n_phase)
                    PH_IDENT: begin
                        b.has_step = 1'b1;
                        b.term     = TERM_OK;
                    end
                    PH_OPEN: begin
                        b.term       = TERM_ERR;
                        b.err_code   = ERR_DIGITS;
                        b.err_offset = ofs16(n_digit_start);
                    end
                    PH_DIGITS: begin
                        b.term       = TERM_ERR;
                        b.err_code   = ERR_RBRACK;
                        b.err_offset = ofs16(len);
                    end
                    PH_DOT: begin
                        b.term       = TERM_ERR;
                        b.err_code   = ERR_TRAIL_DOT;
                        b.err_offset = ofs16((len != '0) ? len - OFS_W'(1) : len);
                    end
                    default: b.term = TERM_OK;
                endcase
            end
        end

        // every path starts from the reset state
        if (i_end_of_path) begin
            n_phase       = PH_START;
            n_started     = 1'b0;
            n_failed      = 1'b0;
            n_char_off    = '0;
            n_space_pend  = 1'b0;
            n_space_off   = '0;
            n_digit_start = '0;
            n_idx_acc     = '0;
            n_idx_ovf     = 1'b0;
        end

        o_bundle = b;
        o_push   = i_accept && (b.has_name || b.has_step || (b.term != TERM_NONE));
    end

    `ASSERT_CLK(a_quiet_after_error, r_failed |-> !o_push, "word queued after an error")
    `ASSERT_NEVER(a_acc_over_max, r_idx_acc > IDX_MAX, "index accumulator past maximum")

endmodule

// File: rtl/ppl_queue.sv
`include "assert_macros.svh"

module ppl_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ppl_pkg::t_bundle i_data,
    input  logic             i_pop,
    output ppl_pkg::t_bundle o_head,
    output logic             o_full,
    output logic             o_empty
);
    import ppl_pkg::*;

    localparam int unsigned PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

    t_bundle          r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_full  = (r_cnt == CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);

    `ASSERT_CLK(a_no_push_full, o_full |-> !i_push, "push into full queue")
    `ASSERT_CLK(a_no_pop_empty, o_empty |-> !i_pop, "pop from empty queue")

endmodule

// File: rtl/ppl_back.sv
`include "assert_macros.svh"

module ppl_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ppl_pkg::t_bundle i_head,
    input  logic             i_head_empty,
    output logic             o_head_pop,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [1:0]       o_kind,
    output logic [15:0]      o_name_char,
    output logic             o_has_index,
    output logic [30:0]      o_index_value,
    output logic [2:0]       o_error_code,
    output logic [15:0]      o_error_offset,
    output logic             o_last_of_run
);
    import ppl_pkg::*;

    logic        r_valid, n_valid;
    logic        r_done_name, n_done_name;
    logic        r_done_step, n_done_step;
    t_kind       r_kind, n_kind;
    logic [15:0] r_name, n_name;
    logic        r_hasi, n_hasi;
    logic [30:0] r_idx, n_idx;
    t_err        r_code, n_code;
    logic [15:0] r_off, n_off;
    logic        r_last, n_last;

    always_comb begin
        logic load;
        logic rem_name;
        logic rem_step;
        logic rem_term;

        load     = !r_valid || i_pop;
        rem_name = i_head.has_name && !r_done_name;
        rem_step = i_head.has_step && !r_done_step;
        rem_term = (i_head.term != TERM_NONE);

        n_valid     = r_valid;
        n_done_name = r_done_name;
        n_done_step = r_done_step;
        n_kind      = r_kind;
        n_name      = r_name;
        n_hasi      = r_hasi;
        n_idx       = r_idx;
        n_code      = r_code;
        n_off       = r_off;
        n_last      = r_last;
        o_head_pop  = 1'b0;

        if (load) begin
            n_valid = !i_head_empty;
            if (!i_head_empty) begin
                n_name = '0;
                n_hasi = 1'b0;
                n_idx  = '0;
                n_code = ERR_IDENT;
                n_off  = '0;
                priority if (rem_name) begin
                    n_kind      = KIND_NAME;
                    n_name      = i_head.name_char;
                    n_last      = !(rem_step || rem_term);
                    n_done_name = 1'b1;
                end else if (rem_step) begin
                    n_kind      = KIND_STEP;
                    n_hasi      = i_head.step_has_index;
                    n_idx       = i_head.step_index;
                    n_last      = !rem_term;
                    n_done_step = 1'b1;
                end else if (i_head.term == TERM_ERR) begin
                    n_kind = KIND_ERR;
                    n_code = i_head.err_code;
                    n_off  = i_head.err_offset;
                    n_last = 1'b1;
                end else begin
                    n_kind = KIND_OK;
                    n_last = 1'b1;
                end
                if (n_last) begin
                    o_head_pop  = 1'b1;
                    n_done_name = 1'b0;
                    n_done_step = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_done_name <= 1'b0;
            r_done_step <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_done_name <= n_done_name;
            r_done_step <= n_done_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_name <= n_name;
        r_hasi <= n_hasi;
        r_idx  <= n_idx;
        r_code <= n_code;
        r_off  <= n_off;
        r_last <= n_last;
    end

    assign o_valid        = r_valid;
    assign o_kind         = r_kind;
    assign o_name_char    = r_name;
    assign o_has_index    = r_hasi;
    assign o_index_value  = r_idx;
    assign o_error_code   = r_code;
    assign o_error_offset = r_off;
    assign o_last_of_run  = r_last;

    `ASSERT_CLK(a_term_is_last,
        r_valid && (r_kind == KIND_OK || r_kind == KIND_ERR) |-> r_last,
        "path result word not marked last")

endmodule

// File: rtl/property_path_lexer_core.sv
// Property path lexer. Characters enter as 16-bit words, one per cycle while
// full is low, with i_end_of_path on the last one of each path; the block
// streams out name characters, a step-done word per step (with its bracketed
// index if any) and one closing ok or error word per path, the error carrying
// its code and the offset into the path with leading whitespace dropped. Input
// and output look like queues: a word goes in when push is high and full is
// low, and comes out when pop is high and empty is low. The front end decodes
// one character every cycle that push is high and full is low, and puts all
// the words that character causes into a four-entry queue; the back end unpacks
// them onto the output register one word per cycle while that register is
// empty or popped. A character may cause up to three words, so the output
// register pass is the limit when many characters cause more than one word. A
// result passes through the queue and then the output register to the output.
`include "assert_macros.svh"

module property_path_lexer_core #(
    parameter int unsigned MAX_PATH_LEN = ppl_pkg::MAX_PATH_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // character side
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_chr,
    input  logic        i_end_of_path,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [15:0] o_name_char,
    output logic        o_has_index,
    output logic [30:0] o_index_value,
    output logic [2:0]  o_error_code,
    output logic [15:0] o_error_offset,
    output logic        o_last_of_run
);
    import ppl_pkg::*;

    logic    accept;
    logic    q_push;
    t_bundle q_in;
    t_bundle q_head;
    logic    q_full;
    logic    q_empty;
    logic    q_pop;
    logic    out_valid;

    // a character is taken whenever the queue has room for its words
    assign full   = q_full;
    assign accept = push && !q_full;

    ppl_front #(
        .MAX_PATH_LEN (MAX_PATH_LEN)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_chr         (i_chr),
        .i_end_of_path (i_end_of_path),
        .o_push        (q_push),
        .o_bundle      (q_in)
    );

    // words of one character travel together through this queue
    ppl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // unpacks the queue head one word per cycle into the output register while it is empty or popped
    ppl_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (q_head),
        .i_head_empty   (q_empty),
        .o_head_pop     (q_pop),
        .i_pop          (pop && out_valid),
        .o_valid        (out_valid),
        .o_kind         (o_kind),
        .o_name_char    (o_name_char),
        .o_has_index    (o_has_index),
        .o_index_value  (o_index_value),
        .o_error_code   (o_error_code),
        .o_error_offset (o_error_offset),
        .o_last_of_run  (o_last_of_run)
    );

    assign empty = !out_valid;

    // a character that causes words must find them in the queue next cycle
    `ASSERT_CLK(a_words_queued, q_push |=> !q_empty, "queued words lost")

endmodule
